// File: design/looping_sample_player_assert.svh
// assertion macros for the looping sample player checker
// included by the checker file, no other dependencies
`ifndef LOOPING_SAMPLE_PLAYER_ASSERT_SVH
`define LOOPING_SAMPLE_PLAYER_ASSERT_SVH

// implication checked at every clock edge outside reset
`define LSP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("looping_sample_player assertion failed");

// signal held while a condition stalls it
`define LSP_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(cond) |=> $stable(sig)) \
		else $error("looping_sample_player hold assertion failed");

`endif

// File: design/lsp_pkg.sv
// shared types, codes and defaults of the looping sample player
// no dependencies
package lsp_pkg;

	localparam int CHANNELS_DEF  = 2;
	localparam int FRAMES_DEF    = 65536;
	localparam int FRAC_BITS_DEF = 16;

	localparam int PHASE_INT_BITS = 17;
	localparam int SAMPLE_W       = 16;
	localparam int CFG_W          = 17;
	localparam logic [16:0] LOOP_END_RESET = 17'd65536;

	localparam logic [1:0] FUNC_PLAY   = 2'd0;
	localparam logic [1:0] FUNC_LOAD   = 2'd1;
	localparam logic [1:0] FUNC_SETPOS = 2'd2;

	localparam logic CFG_LOOP_START = 1'b0;
	localparam logic CFG_LOOP_END   = 1'b1;

	typedef struct packed {
		logic [1:0]         func;
		logic [23:0]        rate;
		logic [1:0]         loop_flags;
		logic               load_channel;
		logic [15:0]        load_index;
		logic signed [15:0] load_value;
		logic [31:0]        position;
	} in_item_t;

	typedef struct packed {
		logic               channel;
		logic signed [15:0] sample_out;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic channel;
		logic last;
		logic zero;
	} rd_info_t;

endpackage

// File: design/lsp_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module lsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: design/lsp_ctrl.sv
// item intake, loop registers, phase accumulator and per-channel read sequencer
// depends on lsp_pkg
module lsp_ctrl #(
	parameter int CHANNELS  = lsp_pkg::CHANNELS_DEF,
	parameter int FRAMES    = lsp_pkg::FRAMES_DEF,
	parameter int FRAC_BITS = lsp_pkg::FRAC_BITS_DEF,
	localparam int IDXW = $clog2(FRAMES),
	localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
	localparam int AW   = $clog2(CHANNELS << IDXW)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lsp_pkg::in_item_t     in_item,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [lsp_pkg::CFG_W-1:0] cfg_data,
	input  logic                  out_ready,
	output lsp_pkg::rd_info_t     rd_info,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output logic [lsp_pkg::SAMPLE_W-1:0] wr_data,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr
);
	import lsp_pkg::*;

	localparam int PB = PHASE_INT_BITS + FRAC_BITS;
	localparam logic [CHW-1:0] LAST_CH = CHW'(CHANNELS - 1);

	logic [PB-1:0] phase_q;
	logic [PB-1:0] phase_j;
	logic [PB-1:0] phase_sat;
	logic [PB-1:0] rate_ph;
	logic [PB-1:0] pos_ph;
	logic [PB:0]   sum;
	logic [16:0]   ip;
	logic [16:0]   rd_idx;
	logic [15:0]   loop_start_q;
	logic [16:0]   loop_end_q;
	logic          busy_q;
	logic [CHW-1:0] cnt_q;
	logic [1:0]    flags_q;
	logic [23:0]   rate_q;
	logic          valid_s1;
	logic          channel_s1;
	logic          last_s1;
	logic          zero_s1;
	logic          adv;
	logic          issue;
	logic          last_ch;
	logic          accept;
	logic          loops;
	logic          hit;
	logic          jump;
	logic          rd_zero;

	assign adv      = !valid_s1 || out_ready;
	assign issue    = busy_q && adv;
	assign last_ch  = (cnt_q == LAST_CH);
	assign in_ready = !busy_q || (adv && last_ch);
	assign accept   = in_valid && in_ready;

	if (FRAC_BITS >= 16) begin : g_up
		assign rate_ph = PB'(rate_q) << (FRAC_BITS - 16);
		assign pos_ph  = PB'(in_item.position) << (FRAC_BITS - 16);
	end else begin : g_dn
		assign rate_ph = PB'(rate_q >> (16 - FRAC_BITS));
		assign pos_ph  = PB'(in_item.position >> (16 - FRAC_BITS));
	end

	always_comb begin
		ip        = phase_q[PB-1:FRAC_BITS];
		loops     = (32'(cnt_q) < 2) && flags_q[cnt_q[0]];
		hit       = (ip < loop_end_q);
		jump      = !hit && loops;
		phase_j   = jump ? (PB'(loop_start_q) << FRAC_BITS) : phase_q;
		rd_idx    = hit ? ip : {1'b0, loop_start_q};
		rd_zero   = !(hit || loops) || (rd_idx >= 17'(FRAMES));
		sum       = {1'b0, phase_j} + {1'b0, rate_ph};
		phase_sat = sum[PB] ? '1 : sum[PB-1:0];
	end

	assign rd_en   = issue;
	assign rd_addr = AW'({cnt_q, rd_idx[IDXW-1:0]});

	assign wr_en   = accept && (in_item.func == FUNC_LOAD)
		&& ({1'b0, in_item.load_index} < 17'(FRAMES))
		&& (32'(in_item.load_channel) < CHANNELS);
	assign wr_addr = AW'({CHW'(in_item.load_channel), in_item.load_index[IDXW-1:0]});
	assign wr_data = in_item.load_value;

	assign rd_info = '{valid: valid_s1, channel: channel_s1, last: last_s1, zero: zero_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_start_q <= '0;
			loop_end_q   <= LOOP_END_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LOOP_START: loop_start_q <= cfg_data[15:0];
				CFG_LOOP_END:   loop_end_q   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept && (in_item.func == FUNC_SETPOS)) begin
			phase_q <= pos_ph;
		end else if (issue) begin
			phase_q <= last_ch ? phase_sat : phase_j;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept && (in_item.func == FUNC_PLAY)) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (issue) begin
			if (last_ch) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (in_item.func == FUNC_PLAY)) begin
			flags_q <= in_item.loop_flags;
			rate_q  <= in_item.rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			channel_s1 <= cnt_q[0];
			last_s1    <= last_ch;
			zero_s1    <= rd_zero;
		end
	end
endmodule

// File: design/looping_sample_player.sv
// looping sample player: a play item gives one sample per channel, one item per cycle
// while out_ready holds, through the busy register and then the registered ram read;
// a play item takes one read per channel of the single sample ram read port, load and
// set-position items none. reset clears the phase, the loop registers (start 0, end
// 65536) and the pipeline; sample ram contents stay undefined until loaded
module looping_sample_player #(
	parameter int CHANNELS  = lsp_pkg::CHANNELS_DEF,
	parameter int FRAMES    = lsp_pkg::FRAMES_DEF,
	parameter int FRAC_BITS = lsp_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lsp_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output lsp_pkg::out_item_t        out_item,
	input  logic                      cfg_we,
	input  logic                      cfg_idx,
	input  logic [lsp_pkg::CFG_W-1:0] cfg_data
);
	import lsp_pkg::*;

	localparam int IDXW  = $clog2(FRAMES);
	localparam int DEPTH = CHANNELS << IDXW;
	localparam int AW    = $clog2(DEPTH);

	rd_info_t              rd_info;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [SAMPLE_W-1:0]   wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [SAMPLE_W-1:0]   rd_data;

	lsp_ctrl #(
		.CHANNELS (CHANNELS),
		.FRAMES   (FRAMES),
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.out_ready(out_ready),
		.rd_info  (rd_info),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr)
	);

	lsp_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign out_valid           = rd_info.valid;
	assign out_item.channel    = rd_info.channel;
	assign out_item.last       = rd_info.last;
	assign out_item.sample_out = rd_info.zero ? '0 : rd_data;
endmodule

// File: design/lsp_checker.sv
// port-level checker of the looping sample player output channel, with its bind
// depends on lsp_pkg and looping_sample_player_assert.svh
`include "looping_sample_player_assert.svh"

module lsp_port_checker #(
	parameter int CHANNELS = lsp_pkg::CHANNELS_DEF,
	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input lsp_pkg::out_item_t out_item
);
	import lsp_pkg::*;

	localparam logic [CHW-1:0] LAST_CH = CHW'(CHANNELS - 1);

	logic [CHW-1:0] exp_ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ch_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_ch_q <= out_item.last ? '0 : exp_ch_q + 1'b1;
		end
	end

	`LSP_ASSERT(a_valid_holds, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`LSP_ASSERT_HOLD(a_item_holds, clk, arst_n, out_valid && !out_ready, out_item)
	`LSP_ASSERT(a_channel_order, clk, arst_n, out_valid |-> out_item.channel == exp_ch_q[0])
	`LSP_ASSERT(a_last_flag, clk, arst_n, out_valid |-> out_item.last == (exp_ch_q == LAST_CH))
endmodule

bind looping_sample_player lsp_port_checker #(.CHANNELS(CHANNELS)) u_lsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
